// ----- rtl/core/bmne_pkg.sv -----
// Shared types and constants for the BLE-MIDI note event extractor.
// No dependencies; used by every module of the block.
package bmne_pkg;

  // Queue between deframer and message assembler
  localparam int unsigned FifoDepthDefault = 4;

  // MIDI status nibbles
  localparam logic [3:0] NibNoteOff = 4'h8;
  localparam logic [3:0] NibNoteOn  = 4'h9;
  localparam logic [3:0] NibCtrlChg = 4'hB;
  localparam logic [3:0] NibSystem  = 4'hF;

  // Register byte addresses (word index taken from paddr[2])
  localparam logic RegPrioChanA = 1'b0;
  localparam logic RegPrioChanB = 1'b1;

  // Deframer phase, one-hot
  typedef enum logic [2:0] {
    PhExpectTs = 3'b001,
    PhAfterTs  = 3'b010,
    PhData     = 3'b100
  } phase_e;

  // Byte handed from the deframer to the queue
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } fwd_beat_t;

  // Configuration seen by the assembler
  typedef struct packed {
    logic [3:0] prio_chan_a;
    logic [3:0] prio_chan_b;
  } cfg_t;

  // Status byte kinds that are passed on
  function automatic logic is_kept_status(input logic [7:0] b);
    return (b[7:4] == NibNoteOff) || (b[7:4] == NibNoteOn) || (b[7:4] == NibCtrlChg);
  endfunction

endpackage

// ----- rtl/core/bmne_deframer.sv -----
// Front end: strips BLE-MIDI header/timestamp bytes and filters statuses.
// Depends on bmne_pkg.
module bmne_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          packet_byte_i,
  input  logic                packet_start_i,
  output bmne_pkg::fwd_beat_t fwd_o
);

  bmne_pkg::phase_e phase_q, phase_d;
  logic running_q, running_d;
  logic forward_q, forward_d;
  logic msb;

  assign msb = packet_byte_i[7];

  // Phase tracking and byte classification
  always_comb begin
    phase_d      = phase_q;
    running_d    = running_q;
    forward_d    = forward_q;
    fwd_o.valid  = 1'b0;
    fwd_o.data   = packet_byte_i;
    if (packet_start_i) begin
      phase_d = bmne_pkg::PhExpectTs;
    end else begin
      unique case (phase_q)
        bmne_pkg::PhAfterTs: begin
          phase_d = bmne_pkg::PhData;
          if (msb) begin
            if (bmne_pkg::is_kept_status(packet_byte_i)) begin
              running_d   = 1'b1;
              forward_d   = 1'b1;
              fwd_o.valid = 1'b1;
            end else begin
              forward_d = 1'b0;
              // channel status clears running status, system status does not
              if (packet_byte_i[7:4] != bmne_pkg::NibSystem) begin
                running_d = 1'b0;
              end
            end
          end else begin
            forward_d   = running_q;
            fwd_o.valid = running_q;
          end
        end
        bmne_pkg::PhData: begin
          if (msb) begin
            phase_d = bmne_pkg::PhAfterTs;
          end else begin
            fwd_o.valid = forward_q;
          end
        end
        default: begin
          phase_d = msb ? bmne_pkg::PhAfterTs : bmne_pkg::PhExpectTs;
        end
      endcase
    end
    fwd_o.valid = fwd_o.valid & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bmne_pkg::PhExpectTs;
      running_q <= 1'b0;
      forward_q <= 1'b1;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      running_q <= running_d;
      forward_q <= forward_d;
    end
  end

endmodule

// ----- rtl/core/bmne_fifo.sv -----
// Small byte queue decoupling the deframer from the message assembler.
// Depends on bmne_pkg.
module bmne_fifo #(
  parameter int unsigned Depth = bmne_pkg::FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmne_pkg::fwd_beat_t push_i,
  output logic                full_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [7:0]          data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [7:0]      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/bmne_assembler.sv -----
// Back end: builds three-byte messages with running status, scales velocity.
// Depends on bmne_pkg.
module bmne_assembler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bmne_pkg::cfg_t cfg_i,
  input  logic           empty_i,
  input  logic [7:0]     data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     status_byte_o,
  output logic [6:0]     first_data_o,
  output logic [6:0]     second_data_o
);

  logic [7:0] status_q, status_d;
  logic [6:0] held_q, held_d;
  logic       count_q, count_d;
  logic       valid_q;
  logic [7:0] o_status_q;
  logic [6:0] o_first_q, o_second_q;
  logic       emit;
  logic [6:0] vel;
  logic       out_free;

  // Output register frees when empty or when its beat is taken
  assign out_free = ~valid_q | ~out_stall_i;
  assign pop_o    = out_free & ~empty_i;

  // Message assembly
  always_comb begin
    status_d = status_q;
    held_d   = held_q;
    count_d  = count_q;
    emit     = 1'b0;
    vel      = data_i[6:0];
    if (data_i[7]) begin
      if (bmne_pkg::is_kept_status(data_i)) begin
        status_d = data_i;
        count_d  = 1'b0;
      end else begin
        status_d = '0;
      end
    end else if (status_q != '0) begin
      if (!count_q) begin
        held_d  = data_i[6:0];
        count_d = 1'b1;
      end else begin
        count_d = 1'b0;
        emit    = 1'b1;
        // halve non-priority note-on velocity, floor of 1
        if ((status_q[7:4] == bmne_pkg::NibNoteOn) && (data_i[6:0] != '0) &&
            (status_q[3:0] != cfg_i.prio_chan_a) &&
            (status_q[3:0] != cfg_i.prio_chan_b)) begin
          vel = (data_i[6:1] == '0) ? 7'd1 : {1'b0, data_i[6:1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      held_q   <= '0;
      count_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        status_q <= status_d;
        held_q   <= held_d;
        count_q  <= count_d;
      end
      if (out_free) begin
        valid_q <= pop_o & emit;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      o_status_q <= status_q;
      o_first_q  <= held_q;
      o_second_q <= vel;
    end
  end

  assign out_valid_o   = valid_q;
  assign status_byte_o = o_status_q;
  assign first_data_o  = o_first_q;
  assign second_data_o = o_second_q;

endmodule

// ----- rtl/core/ble_midi_note_event_extractor_unit.sv -----
// Top level of the BLE-MIDI note event extractor: register port and wiring.
// Depends on bmne_pkg, bmne_deframer, bmne_fifo, bmne_assembler.

// Takes one BLE-MIDI packet byte per cycle and emits note-off, note-on and
// control-change messages with running status kept across packets. A byte
// is accepted every cycle unless the byte queue between deframer and
// assembler is full (FifoDepth entries); the assembler drains one byte per
// cycle while the output register is free, so sustained rate is one byte
// per clock. A completed message passes through the byte queue and then
// the output register. Registers at byte address 0 and 4 hold the two
// priority channels whose note-on velocity passes unscaled; write them
// only while the block is idle.
module ble_midi_note_event_extractor_unit #(
  parameter int unsigned FifoDepth = bmne_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  packet_byte_i,
  input  logic        packet_start_i,
  // messages
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  status_byte_o,
  output logic [6:0]  first_data_o,
  output logic [6:0]  second_data_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bmne_pkg::cfg_t      cfg_q;
  bmne_pkg::fwd_beat_t fwd;
  logic                fifo_full, fifo_empty, fifo_pop;
  logic [7:0]          fifo_data;
  logic                in_accept;
  logic                reg_wr;

  // Register port
  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prio_chan_a <= 4'd0;
      cfg_q.prio_chan_b <= 4'd1;
    end else if (reg_wr) begin
      unique case (paddr[2])
        bmne_pkg::RegPrioChanA: cfg_q.prio_chan_a <= pwdata[3:0];
        bmne_pkg::RegPrioChanB: cfg_q.prio_chan_b <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bmne_pkg::RegPrioChanA: prdata = {28'd0, cfg_q.prio_chan_a};
      bmne_pkg::RegPrioChanB: prdata = {28'd0, cfg_q.prio_chan_b};
      default:                prdata = '0;
    endcase
  end

  // Input handshake
  assign in_stall_o = fifo_full;
  assign in_accept  = in_valid_i & ~fifo_full;

  bmne_deframer u_deframer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .packet_byte_i  (packet_byte_i),
    .packet_start_i (packet_start_i),
    .fwd_o          (fwd)
  );

  bmne_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fwd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .pop_i   (fifo_pop),
    .data_o  (fifo_data)
  );

  bmne_assembler u_assembler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (fifo_empty),
    .data_i        (fifo_data),
    .pop_o         (fifo_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_byte_o (status_byte_o),
    .first_data_o  (first_data_o),
    .second_data_o (second_data_o)
  );

endmodule
